[rtl/lhp_pkg.sv]
`default_nettype none

package lhp_pkg;

  localparam int Buckets  = 32;
  localparam int IdxW     = $clog2(Buckets);
  localparam int OutBktW  = 5;
  localparam int CntW     = 64;
  localparam int PctW     = 7;
  localparam int ProdW    = CntW + PctW;
  localparam int NumPct   = 3;
  localparam int PctScale = 100;
  localparam int DataW    = 32;
  localparam int AddrW    = 4;

  localparam logic [PctW-1:0] PctLowRst  = PctW'(50);
  localparam logic [PctW-1:0] PctMidRst  = PctW'(90);
  localparam logic [PctW-1:0] PctHighRst = PctW'(95);

  typedef enum logic [1:0] {
    RegPctLow  = 2'd0,
    RegPctMid  = 2'd1,
    RegPctHigh = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            start;
    logic            capture;
  } lhp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } lhp_sts_t;

  typedef struct packed {
    logic               empty_res;
    logic [OutBktW-1:0] bucket_low;
    logic [OutBktW-1:0] bucket_mid;
    logic [OutBktW-1:0] bucket_high;
    logic [OutBktW-1:0] top_bucket;
    logic [CntW-1:0]    sample_total;
  } lhp_res_t;

endpackage

`default_nettype wire

[rtl/lhp_in_if.sv]
`default_nettype none

interface lhp_in_if;
  logic                      valid;
  logic                      ready;
  logic [lhp_pkg::CntW-1:0]  count_before;
  logic [lhp_pkg::CntW-1:0]  count_after;

  modport source (output valid, output count_before, output count_after, input ready);
  modport sink   (input valid, input count_before, input count_after, output ready);
endinterface

`default_nettype wire

[rtl/lhp_out_if.sv]
`default_nettype none

interface lhp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          empty_res;
  logic [lhp_pkg::OutBktW-1:0]   bucket_low;
  logic [lhp_pkg::OutBktW-1:0]   bucket_mid;
  logic [lhp_pkg::OutBktW-1:0]   bucket_high;
  logic [lhp_pkg::OutBktW-1:0]   top_bucket;
  logic [lhp_pkg::CntW-1:0]      sample_total;

  modport source (output valid, output empty_res, output bucket_low, output bucket_mid,
                  output bucket_high, output top_bucket, output sample_total, input ready);
  modport sink   (input valid, input empty_res, input bucket_low, input bucket_mid,
                  input bucket_high, input top_bucket, input sample_total, output ready);
endinterface

`default_nettype wire

[rtl/lhp_ram.sv]
`default_nettype none

module lhp_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/lhp_ctrl.sv]
`default_nettype none

module lhp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_free_i,
  input  wire lhp_pkg::lhp_sts_t sts_i,
  output logic                   in_ready_o,
  output lhp_pkg::lhp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StWalk  = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  localparam logic [lhp_pkg::IdxW-1:0] LastIdx = lhp_pkg::IdxW'(lhp_pkg::Buckets - 1);

  state_e                      state_q, state_d;
  logic [lhp_pkg::IdxW-1:0]    load_idx_q, load_idx_d;
  logic [lhp_pkg::IdxW-1:0]    walk_idx_q, walk_idx_d;
  logic                        accept;

  assign in_ready_o = (state_q == StLoad);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d       = state_q;
    load_idx_d    = load_idx_q;
    walk_idx_d    = walk_idx_q;
    cmd_o         = '0;
    cmd_o.wr_idx  = load_idx_q;
    cmd_o.rd_idx  = walk_idx_q;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          cmd_o.wr_en = 1'b1;
          if (load_idx_q == LastIdx) begin
            load_idx_d = '0;
            walk_idx_d = '0;
            state_d    = StWalk;
          end else begin
            load_idx_d = load_idx_q + 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.start = (walk_idx_q == '0);
        if (walk_idx_q == LastIdx) begin
          state_d = StDrain;
        end else begin
          walk_idx_d = walk_idx_q + 1'b1;
        end
      end
      StDrain: begin
        if (sts_i.walk_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      load_idx_q <= '0;
      walk_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      walk_idx_q <= walk_idx_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lhp_dp.sv]
`default_nettype none

module lhp_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lhp_pkg::lhp_cmd_t          cmd_i,
  input  wire logic [lhp_pkg::CntW-1:0]   count_before_i,
  input  wire logic [lhp_pkg::CntW-1:0]   count_after_i,
  input  wire logic [lhp_pkg::PctW-1:0]   pct_low_i,
  input  wire logic [lhp_pkg::PctW-1:0]   pct_mid_i,
  input  wire logic [lhp_pkg::PctW-1:0]   pct_high_i,
  output lhp_pkg::lhp_sts_t               sts_o,
  output lhp_pkg::lhp_res_t               res_o
);

  localparam int CntW  = lhp_pkg::CntW;
  localparam int ProdW = lhp_pkg::ProdW;
  localparam int IdxW  = lhp_pkg::IdxW;
  localparam int NumPct = lhp_pkg::NumPct;
  localparam int PctW_L = lhp_pkg::PctW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(lhp_pkg::Buckets - 1);

  logic [CntW-1:0]  delta;
  logic [CntW-1:0]  rdata;
  logic [CntW-1:0]  total_q;
  logic [IdxW-1:0]  top_q;
  logic [CntW-1:0]  cum_q;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] thr_q   [NumPct];
  logic [PctW_L-1:0] pct    [NumPct];
  logic [IdxW-1:0]  bkt_q   [NumPct];
  logic [NumPct-1:0] found_q;
  logic             v1_q, v2_q, v3_q;
  logic [IdxW-1:0]  b1_q, b2_q, b3_q;
  logic             empty;

  assign delta  = count_after_i - count_before_i;
  assign pct[0] = pct_low_i;
  assign pct[1] = pct_mid_i;
  assign pct[2] = pct_high_i;

  lhp_ram #(
    .Width(CntW),
    .Depth(lhp_pkg::Buckets)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_idx),
    .wdata_i(delta),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_idx),
    .rdata_o(rdata)
  );

  // totals of the histogram being loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      top_q   <= '0;
    end else if (cmd_i.capture) begin
      total_q <= '0;
      top_q   <= '0;
    end else if (cmd_i.wr_en) begin
      total_q <= total_q + delta;
      if (delta != '0) begin
        top_q <= cmd_i.wr_idx;
      end
    end
  end

  // walk pipeline: read, accumulate, scale, compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= '0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.start) begin
        found_q <= '0;
      end else if (v3_q) begin
        for (int k = 0; k < NumPct; k++) begin
          if (prod_q >= thr_q[k]) begin
            found_q[k] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q <= cmd_i.rd_idx;
    b2_q <= b1_q;
    b3_q <= b2_q;
    if (cmd_i.start) begin
      cum_q <= '0;
    end else if (v1_q) begin
      cum_q <= cum_q + rdata;
    end
    if (v2_q) begin
      prod_q <= ProdW'(cum_q) * ProdW'(lhp_pkg::PctScale);
    end
    for (int k = 0; k < NumPct; k++) begin
      if (cmd_i.start) begin
        thr_q[k] <= ProdW'(total_q) * ProdW'(pct[k]);
        bkt_q[k] <= LastIdx;
      end else if (v3_q && !found_q[k] && (prod_q >= thr_q[k])) begin
        bkt_q[k] <= b3_q;
      end
    end
  end

  assign sts_o.walk_done = v3_q && (b3_q == LastIdx);

  assign empty = (total_q == '0);

  always_comb begin
    res_o              = '0;
    res_o.empty_res    = empty;
    if (!empty) begin
      res_o.bucket_low   = lhp_pkg::OutBktW'(bkt_q[0]);
      res_o.bucket_mid   = lhp_pkg::OutBktW'(bkt_q[1]);
      res_o.bucket_high  = lhp_pkg::OutBktW'(bkt_q[2]);
      res_o.top_bucket   = lhp_pkg::OutBktW'(top_q);
      res_o.sample_total = total_q;
    end
  end

endmodule

`default_nettype wire

[rtl/log2_histogram_percentile_unit.sv]
`default_nettype none

// Channel | Dir | Word
// in_i    | in  | count_before, count_after (one bucket, bucket order)
// out_o   | out | empty_res, bucket_low/mid/high, top_bucket, sample_total
// apb     | in  | pct_low @0x0, pct_mid @0x4, pct_high @0x8
//
// Buckets load one per cycle while the source keeps valid high; after the last one the single store
// read port walks all buckets, one per cycle, through the read, accumulate, scale and compare pipeline,
// then the result is handed off to the output register once that register is free.
// No input is taken during the walk. The result sits in an output register;
// loading of the next histogram proceeds while it waits to be taken.
// Reset is asynchronous and active low; it restores the default percentages.

module log2_histogram_percentile_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lhp_in_if.sink                           in_i,
  lhp_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lhp_pkg::AddrW-1:0]   paddr,
  input  wire logic [lhp_pkg::DataW-1:0]   pwdata,
  output logic      [lhp_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  logic [lhp_pkg::PctW-1:0] pct_low_q, pct_mid_q, pct_high_q;
  lhp_pkg::lhp_cmd_t        cmd;
  lhp_pkg::lhp_sts_t        sts;
  lhp_pkg::lhp_res_t        res;
  lhp_pkg::lhp_res_t        out_res_q;
  logic                     out_valid_q;
  logic                     out_free;
  logic                     cfg_we;
  lhp_pkg::reg_idx_e        reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = lhp_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_low_q  <= lhp_pkg::PctLowRst;
      pct_mid_q  <= lhp_pkg::PctMidRst;
      pct_high_q <= lhp_pkg::PctHighRst;
    end else if (cfg_we) begin
      unique case (reg_idx)
        lhp_pkg::RegPctLow:  pct_low_q  <= pwdata[lhp_pkg::PctW-1:0];
        lhp_pkg::RegPctMid:  pct_mid_q  <= pwdata[lhp_pkg::PctW-1:0];
        lhp_pkg::RegPctHigh: pct_high_q <= pwdata[lhp_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lhp_pkg::RegPctLow:  prdata = lhp_pkg::DataW'(pct_low_q);
      lhp_pkg::RegPctMid:  prdata = lhp_pkg::DataW'(pct_mid_q);
      lhp_pkg::RegPctHigh: prdata = lhp_pkg::DataW'(pct_high_q);
      default:             prdata = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;

  lhp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .out_free_i(out_free),
    .sts_i     (sts),
    .in_ready_o(in_i.ready),
    .cmd_o     (cmd)
  );

  lhp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .count_before_i(in_i.count_before),
    .count_after_i (in_i.count_after),
    .pct_low_i     (pct_low_q),
    .pct_mid_i     (pct_mid_q),
    .pct_high_i    (pct_high_q),
    .sts_o         (sts),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.capture) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.empty_res    = out_res_q.empty_res;
  assign out_o.bucket_low   = out_res_q.bucket_low;
  assign out_o.bucket_mid   = out_res_q.bucket_mid;
  assign out_o.bucket_high  = out_res_q.bucket_high;
  assign out_o.top_bucket   = out_res_q.top_bucket;
  assign out_o.sample_total = out_res_q.sample_total;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> (!out_valid_q || out_o.ready))
    else $error("pending result overwritten");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.empty_res) |->
      (out_res_q.sample_total == '0 && out_res_q.top_bucket == '0))
    else $error("empty result carries nonzero fields");

  a_no_load_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_en || sts.walk_done) |-> !cmd.wr_en)
    else $error("bucket loaded during walk");

  a_rise_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.capture))
    else $error("result shown without capture");
`endif

endmodule

`default_nettype wire

[tb/tb_log2_histogram_percentile_unit.sv]
`default_nettype none

class lhp_scoreboard;
  logic [lhp_pkg::CntW-1:0]    delta_mem [lhp_pkg::Buckets];
  int unsigned                 load_pos;
  logic [lhp_pkg::CntW-1:0]    delta_sum;
  logic [lhp_pkg::OutBktW-1:0] top_nz;
  bit                          any_nz;
  logic [lhp_pkg::PctW-1:0]    pct [lhp_pkg::NumPct];
  lhp_pkg::lhp_res_t           due_q [$];
  int unsigned                 errors;
  int unsigned                 buckets;
  int unsigned                 checked;
  int unsigned                 empties;

  function new();
    errors  = 0;
    buckets = 0;
    checked = 0;
    empties = 0;
    pct[lhp_pkg::RegPctLow]  = lhp_pkg::PctLowRst;
    pct[lhp_pkg::RegPctMid]  = lhp_pkg::PctMidRst;
    pct[lhp_pkg::RegPctHigh] = lhp_pkg::PctHighRst;
    clear_hist();
  endfunction

  function void clear_hist();
    foreach (delta_mem[i]) delta_mem[i] = '0;
    load_pos  = 0;
    delta_sum = '0;
    top_nz    = '0;
    any_nz    = 1'b0;
  endfunction

  function void write_pct(int unsigned idx, logic [lhp_pkg::DataW-1:0] val);
    if (idx < lhp_pkg::NumPct) begin
      pct[idx] = val[lhp_pkg::PctW-1:0];
    end
  endfunction

  // first bucket whose running count * 100 reaches total * pct, exact at ProdW bits
  function logic [lhp_pkg::OutBktW-1:0] find_bucket(logic [lhp_pkg::PctW-1:0] p);
    logic [lhp_pkg::ProdW-1:0] goal;
    logic [lhp_pkg::ProdW-1:0] reach;
    logic [lhp_pkg::CntW-1:0]  cum;
    goal = lhp_pkg::ProdW'(delta_sum) * lhp_pkg::ProdW'(p);
    cum  = '0;
    for (int b = 0; b < lhp_pkg::Buckets; b++) begin
      cum   = cum + delta_mem[b];
      reach = lhp_pkg::ProdW'(cum) * lhp_pkg::ProdW'(lhp_pkg::PctScale);
      if (reach >= goal) return lhp_pkg::OutBktW'(b);
    end
    return lhp_pkg::OutBktW'(lhp_pkg::Buckets - 1);
  endfunction

  function void note_bucket(logic [lhp_pkg::CntW-1:0] before_cnt,
                            logic [lhp_pkg::CntW-1:0] after_cnt);
    logic [lhp_pkg::CntW-1:0] delta;
    lhp_pkg::lhp_res_t        want;
    delta = after_cnt - before_cnt;
    buckets++;
    delta_mem[load_pos] = delta;
    delta_sum = delta_sum + delta;
    if (delta != '0) begin
      top_nz = lhp_pkg::OutBktW'(load_pos);
      any_nz = 1'b1;
    end
    if (load_pos + 1 < lhp_pkg::Buckets) begin
      load_pos++;
      return;
    end
    want = '0;
    if (delta_sum == '0) begin
      want.empty_res = 1'b1;
    end else begin
      want.bucket_low   = find_bucket(pct[lhp_pkg::RegPctLow]);
      want.bucket_mid   = find_bucket(pct[lhp_pkg::RegPctMid]);
      want.bucket_high  = find_bucket(pct[lhp_pkg::RegPctHigh]);
      want.top_bucket   = any_nz ? top_nz : '0;
      want.sample_total = delta_sum;
    end
    due_q.push_back(want);
    clear_hist();
  endfunction

  function int unsigned pending();
    return due_q.size();
  endfunction

  function void check_result(lhp_pkg::lhp_res_t got);
    lhp_pkg::lhp_res_t want;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected result word: empty=%0d b=%0d/%0d/%0d top=%0d total=%h",
                 got.empty_res, got.bucket_low, got.bucket_mid, got.bucket_high,
                 got.top_bucket, got.sample_total);
      end
      return;
    end
    want = due_q.pop_front();
    checked++;
    if (want.empty_res) empties++;
    if (got.empty_res !== want.empty_res || got.bucket_low !== want.bucket_low ||
        got.bucket_mid !== want.bucket_mid || got.bucket_high !== want.bucket_high ||
        got.top_bucket !== want.top_bucket || got.sample_total !== want.sample_total) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch result %0d: exp empty=%0d b=%0d/%0d/%0d top=%0d total=%h",
                 checked, want.empty_res, want.bucket_low, want.bucket_mid,
                 want.bucket_high, want.top_bucket, want.sample_total);
        $display("                    got empty=%0d b=%0d/%0d/%0d top=%0d total=%h",
                 got.empty_res, got.bucket_low, got.bucket_mid, got.bucket_high,
                 got.top_bucket, got.sample_total);
      end
    end
  endfunction
endclass

module tb_log2_histogram_percentile_unit;

  localparam int unsigned SettleCycles = 2 * lhp_pkg::Buckets + 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RegUnused    = lhp_pkg::NumPct;

  typedef enum int {
    HkEmpty,
    HkCancel,
    HkFlat,
    HkSmall,
    HkSparse,
    HkSingle,
    HkWide,
    HkHuge
  } hist_kind_e;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [lhp_pkg::AddrW-1:0] paddr;
  logic [lhp_pkg::DataW-1:0] pwdata;
  logic [lhp_pkg::DataW-1:0] prdata;
  logic                      pready;

  lhp_in_if  in_if ();
  lhp_out_if out_if ();

  log2_histogram_percentile_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lhp_scoreboard            sb;
  logic [lhp_pkg::CntW-1:0] hist_delta [lhp_pkg::Buckets];
  int unsigned              src_idle_pct;
  int unsigned              snk_idle_pct;
  bit                       hold_req;
  int unsigned              hold_left;
  int unsigned              hist_count;
  lhp_pkg::lhp_res_t        seen_res;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("tb_log2_histogram_percentile_unit failed");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_res.empty_res    = out_if.empty_res;
      seen_res.bucket_low   = out_if.bucket_low;
      seen_res.bucket_mid   = out_if.bucket_mid;
      seen_res.bucket_high  = out_if.bucket_high;
      seen_res.top_bucket   = out_if.top_bucket;
      seen_res.sample_total = out_if.sample_total;
      sb.check_result(seen_res);
    end
  end

  function automatic logic [lhp_pkg::CntW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic reg_write(input int unsigned idx, input logic [lhp_pkg::DataW-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = lhp_pkg::AddrW'(idx * 4);
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_pct(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_bucket(input logic [lhp_pkg::CntW-1:0] before_cnt,
                             input logic [lhp_pkg::CntW-1:0] after_cnt);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.count_before = before_cnt;
    in_if.count_after  = after_cnt;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_bucket(before_cnt, after_cnt);
  endtask

  task automatic run_hist(input hist_kind_e kind, input int unsigned pos);
    logic [lhp_pkg::CntW-1:0] acc;
    logic [lhp_pkg::CntW-1:0] base;
    acc = '0;
    foreach (hist_delta[i]) hist_delta[i] = '0;
    case (kind)
      HkCancel: begin
        for (int i = 0; i < lhp_pkg::Buckets - 1; i++) begin
          hist_delta[i] = rand64();
          acc = acc + hist_delta[i];
        end
        hist_delta[lhp_pkg::Buckets-1] = '0 - acc;
      end
      HkFlat: begin
        foreach (hist_delta[i]) hist_delta[i] = lhp_pkg::CntW'(1);
      end
      HkSmall: begin
        foreach (hist_delta[i]) begin
          hist_delta[i] = ($urandom_range(0, 3) == 0) ? '0 :
                          lhp_pkg::CntW'($urandom_range(1, 1000));
        end
      end
      HkSparse: begin
        repeat ($urandom_range(1, 4)) begin
          hist_delta[$urandom_range(0, lhp_pkg::Buckets - 1)] =
            lhp_pkg::CntW'($urandom_range(1, 1 << 20));
        end
      end
      HkSingle: begin
        hist_delta[pos] = $urandom_range(0, 1) ? lhp_pkg::CntW'(1) : '1;
      end
      HkWide: begin
        foreach (hist_delta[i]) hist_delta[i] = rand64();
      end
      HkHuge: begin
        foreach (hist_delta[i]) begin
          if ($urandom_range(0, 1)) begin
            hist_delta[i] = rand64() | {1'b1, {(lhp_pkg::CntW - 1){1'b0}}};
          end
        end
      end
      default: begin
      end
    endcase
    foreach (hist_delta[i]) begin
      case ($urandom_range(0, 7))
        0:       base = '0;
        1:       base = '1;
        default: base = rand64();
      endcase
      send_bucket(base, base + hist_delta[i]);
    end
    hist_count++;
  endtask

  function automatic hist_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return HkSmall;
    if (r < 65) return HkSparse;
    if (r < 75) return HkSingle;
    if (r < 83) return HkWide;
    if (r < 90) return HkHuge;
    if (r < 95) return HkCancel;
    return HkEmpty;
  endfunction

  function automatic logic [lhp_pkg::DataW-1:0] pick_pct();
    logic [lhp_pkg::DataW-1:0] val;
    case ($urandom_range(0, 5))
      0:       val = 0;
      1:       val = 100;
      2:       val = 127;
      default: val = $urandom_range(0, 100);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      val[lhp_pkg::DataW-1:lhp_pkg::PctW] = (lhp_pkg::DataW - lhp_pkg::PctW)'($urandom());
    end
    return val;
  endfunction

  // stop offering, let every due result drain, then give the walk time to finish
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    sb                 = new();
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.count_before = '0;
    in_if.count_after  = '0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    hold_req           = 1'b0;
    hold_left          = 0;
    hist_count         = 0;
    src_idle_pct       = 8;
    snk_idle_pct       = 53;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset percentages
    run_hist(HkEmpty, 0);
    run_hist(HkSingle, 0);
    run_hist(HkSingle, lhp_pkg::Buckets - 1);
    run_hist(HkCancel, 0);
    run_hist(HkFlat, 0);
    settle();

    // zero, full and over-range percentages, upper bits ignored, bad index dropped
    reg_write(lhp_pkg::RegPctLow, 0);
    reg_write(lhp_pkg::RegPctMid, 100);
    reg_write(lhp_pkg::RegPctHigh, {{(lhp_pkg::DataW - lhp_pkg::PctW){1'b1}}, 7'd127});
    reg_write(RegUnused, '1);
    run_hist(HkFlat, 0);
    run_hist(HkWide, 0);
    run_hist(HkHuge, 0);
    run_hist(HkSingle, 17);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      src_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 53 : 0;
      snk_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 8 : 0;
      reg_write(lhp_pkg::RegPctLow, pick_pct());
      reg_write(lhp_pkg::RegPctMid, pick_pct());
      reg_write(lhp_pkg::RegPctHigh, pick_pct());
      if ($urandom_range(0, 1)) reg_write(RegUnused, $urandom());
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      repeat (4) run_hist(pick_kind(), $urandom_range(0, lhp_pkg::Buckets - 1));
    end
    settle();

    $display("%0d histograms (%0d bucket words) loaded, %0d result words checked, %0d empty",
             hist_count, sb.buckets, sb.checked, sb.empties);
    $display("%0d mismatches, %0d results still due", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_log2_histogram_percentile_unit passed");
    end else begin
      $display("tb_log2_histogram_percentile_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/lhp_pkg.sv
rtl/lhp_in_if.sv
rtl/lhp_out_if.sv
rtl/lhp_ram.sv
rtl/lhp_ctrl.sv
rtl/lhp_dp.sv
rtl/log2_histogram_percentile_unit.sv
tb/tb_log2_histogram_percentile_unit.sv
